// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define UBH_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define UBH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ubh_pkg.sv =====
// Shared types, constants and a helper function of the uniform bin histogram.
package ubh_pkg;

   localparam int MAX_BINS_DEF     = 1024;
   localparam int SAMPLE_WIDTH_DEF = 32;
   localparam int CNT_W            = 32;
   localparam int BINS_W           = 11;
   localparam int BWIDTH_W         = 31;
   localparam int IDX_W            = 10;

   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_READ  = 2'd1,
      ACT_CLEAR = 2'd2,
      ACT_SCAN  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_BINS   = 2'd0,
      CSR_BOTTOM = 2'd1,
      CSR_WIDTH  = 2'd2,
      CSR_NONE   = 2'd3
   } csr_index_type;

   // Saturating increment of a count.
   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
   endfunction

endpackage

// ===== sv/ubh_divider.sv =====
// Restoring shift-subtract divider that produces one quotient bit per cycle.
module ubh_divider #(
   parameter int DW = 33,
   parameter int VW = 31,
   parameter int QN = 12
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [QN-1:0] quotient
);

   localparam int CW  = ((DW > VW) ? DW : VW) + QN;
   localparam int CNW = $clog2(QN + 1);

   logic [CW-1:0]  rem_ff;
   logic [CW-1:0]  dvs_ff;
   logic [QN-1:0]  q_ff;
   logic [CNW-1:0] cnt_ff;
   logic           busy_ff;
   logic           done_ff;
   logic           ge;

   assign ge       = rem_ff >= dvs_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= CW'(dividend);
            // The first compare is against the divisor scaled by the top quotient weight.
            dvs_ff  <= CW'(divisor) << (QN - 1);
            q_ff    <= '0;
            cnt_ff  <= CNW'(QN - 1);
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (ge) begin
               rem_ff <= rem_ff - dvs_ff;
            end
            q_ff   <= {q_ff[QN-2:0], ge};
            dvs_ff <= dvs_ff >> 1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - CNW'(1);
            end
         end
      end
   end

endmodule

// ===== sv/ubh_bin_ram.sv =====
// Bin count memory with one write port and one registered read port.
module ubh_bin_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [AW-1:0]           waddr,
   input  logic [ubh_pkg::CNT_W-1:0] wdata,
   input  logic [AW-1:0]           raddr,
   output logic [ubh_pkg::CNT_W-1:0] rdata
);

   logic [ubh_pkg::CNT_W-1:0] mem [DEPTH];
   logic [ubh_pkg::CNT_W-1:0] rdata_ff;

   assign rdata = rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

// ===== sv/uniform_bin_histogram.sv =====
// Top level of the uniform bin histogram: control sequencer, registers and result stage.
//
//  channel | direction | handshake          | payload
//  req_    | in        | req_valid/req_ready | action, sample, bin_index
//  rsp_    | out       | rsp_valid/rsp_ready | status, counts, sample extremes, empty
//  csr_    | in        | csr_we              | csr_index, csr_wdata
//
// An add runs through these steps before the next request can be taken: the accept
// cycle, the serial divider making NW + 1 quotient bits one per cycle, a bin memory
// read, the read-modify-write and the result load. An add at or above the top edge
// skips the memory read and the read-modify-write. A read goes through the memory read
// and the read-modify-write; a rejected read and a below-range add go straight to the
// result load. A scan reads one active bin per cycle from the single read port.
// A clear, a reset and every write to a layout register run a clearing pass over all
// MAX_BINS entries of the bin memory, during which no request is accepted. A finished
// result waits in the output register; the next request is accepted meanwhile and holds
// only when its own result is ready before the previous one has been taken.
module uniform_bin_histogram #(
   parameter int MAX_BINS     = ubh_pkg::MAX_BINS_DEF,
   parameter int SAMPLE_WIDTH = ubh_pkg::SAMPLE_WIDTH_DEF,
   localparam int CSR_W       = (SAMPLE_WIDTH > 32) ? SAMPLE_WIDTH : 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_action,
   input  logic signed [SAMPLE_WIDTH-1:0]  req_sample,
   input  logic [ubh_pkg::IDX_W-1:0]       req_bin_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_status,
   output logic [ubh_pkg::CNT_W-1:0]       rsp_bin_value,
   output logic [ubh_pkg::CNT_W-1:0]       rsp_total_count,
   output logic [ubh_pkg::CNT_W-1:0]       rsp_peak_count,
   output logic [ubh_pkg::CNT_W-1:0]       rsp_least_count,
   output logic [ubh_pkg::CNT_W-1:0]       rsp_below_count,
   output logic [ubh_pkg::CNT_W-1:0]       rsp_above_count,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_min_sample,
   output logic signed [SAMPLE_WIDTH-1:0]  rsp_max_sample,
   output logic                            rsp_empty_res,
   input  logic                            csr_we,
   input  logic [1:0]                      csr_index,
   input  logic [CSR_W-1:0]                csr_wdata
);

   localparam int CW    = ubh_pkg::CNT_W;
   localparam int AW    = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NB    = $clog2(MAX_BINS + 1);
   localparam int NW    = (NB > ubh_pkg::BINS_W) ? NB : ubh_pkg::BINS_W;
   localparam int QN    = NW + 1;
   localparam int DW    = SAMPLE_WIDTH + 1;
   localparam int WW    = ubh_pkg::BWIDTH_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_RDADDR,
      S_RMW,
      S_SCAN,
      S_DONE
   } state_type;

   state_type                      state_ff;
   ubh_pkg::action_type            act_ff;
   logic                           pend_ff;

   logic [ubh_pkg::BINS_W-1:0]     bins_ff;
   logic signed [SAMPLE_WIDTH-1:0] bottom_ff;
   logic [WW-1:0]                  width_ff;

   logic [CW-1:0]                  below_ff;
   logic [CW-1:0]                  above_ff;
   logic [CW-1:0]                  total_ff;
   logic [CW-1:0]                  largest_ff;
   logic signed [SAMPLE_WIDTH-1:0] smallest_seen_ff;
   logic signed [SAMPLE_WIDTH-1:0] largest_seen_ff;
   logic                           empty_ff;

   logic                           status_ff;
   logic [CW-1:0]                  value_ff;
   logic [CW-1:0]                  minc_ff;

   logic [AW-1:0]                  addr_ff;
   logic                           issue_ff;
   logic                           vld_ff;
   logic                           lastv_ff;
   logic                           first_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_status_ff;
   logic [CW-1:0]                  rsp_bin_value_ff;
   logic [CW-1:0]                  rsp_total_ff;
   logic [CW-1:0]                  rsp_max_bin_ff;
   logic [CW-1:0]                  rsp_min_bin_ff;
   logic [CW-1:0]                  rsp_below_ff;
   logic [CW-1:0]                  rsp_above_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_min_sample_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_max_sample_ff;
   logic                           rsp_empty_ff;

   logic [NW-1:0]                  n_act;
   logic [WW-1:0]                  width_eff;
   logic                           accept;
   logic                           is_below;
   logic [DW-1:0]                  diff;
   logic                           div_start;
   logic                           div_done;
   logic [QN-1:0]                  div_q;
   logic                           mem_we;
   logic [CW-1:0]                  mem_wdata;
   logic [CW-1:0]                  mem_rdata;
   logic [CW-1:0]                  bumped;
   logic                           addr_last;
   logic                           addr_end;
   logic                           load_rsp;
   logic                           csr_hit;

   // Active bin count: zero acts as one, values beyond the store depth clamp to it.
   always_comb begin
      if (bins_ff == '0) begin
         n_act = NW'(1);
      end else if (NW'(bins_ff) > NW'(MAX_BINS)) begin
         n_act = NW'(MAX_BINS);
      end else begin
         n_act = NW'(bins_ff);
      end
   end

   assign width_eff = (width_ff == '0) ? WW'(1) : width_ff;
   // A register write takes priority over a request in the same cycle.
   assign req_ready = (state_ff == S_IDLE) && !csr_we;
   assign accept    = req_valid && req_ready;
   assign is_below  = req_sample < bottom_ff;
   // Offset of the sample above the bottom edge; never negative when the divider runs.
   assign diff      = DW'(signed'({req_sample[SAMPLE_WIDTH-1], req_sample})
                      - signed'({bottom_ff[SAMPLE_WIDTH-1], bottom_ff}));
   assign div_start = accept && (req_action == ubh_pkg::ACT_ADD) && !is_below;
   assign bumped    = ubh_pkg::sat_inc(mem_rdata);
   assign mem_we    = (state_ff == S_CLEAR) ||
                      ((state_ff == S_RMW) && (act_ff == ubh_pkg::ACT_ADD));
   assign mem_wdata = (state_ff == S_CLEAR) ? '0 : bumped;
   assign addr_last = (NW'(addr_ff) == (n_act - NW'(1)));
   assign addr_end  = (addr_ff == AW'(MAX_BINS - 1));
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);
   assign csr_hit   = csr_we && (csr_index != ubh_pkg::CSR_NONE);

   ubh_divider #(
      .DW (DW),
      .VW (WW),
      .QN (QN)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff),
      .divisor  (width_eff),
      .done     (div_done),
      .quotient (div_q)
   );

   ubh_bin_ram #(
      .DEPTH (MAX_BINS),
      .AW    (AW)
   ) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (addr_ff),
      .wdata (mem_wdata),
      .raddr (addr_ff),
      .rdata (mem_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         act_ff           <= ubh_pkg::ACT_ADD;
         pend_ff          <= 1'b0;
         addr_ff          <= '0;
         issue_ff         <= 1'b0;
         vld_ff           <= 1'b0;
         lastv_ff         <= 1'b0;
         first_ff         <= 1'b0;
         bins_ff          <= ubh_pkg::BINS_W'(1);
         bottom_ff        <= '0;
         width_ff         <= WW'(1);
         below_ff         <= '0;
         above_ff         <= '0;
         total_ff         <= '0;
         largest_ff       <= '0;
         smallest_seen_ff <= '0;
         largest_seen_ff  <= '0;
         empty_ff         <= 1'b1;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && !load_rsp) begin
            rsp_valid_ff <= 1'b0;
         end

         if (csr_hit) begin
            // A register write changes the bin layout, so all histogram state is cleared.
            case (csr_index)
               ubh_pkg::CSR_BINS:   bins_ff   <= csr_wdata[ubh_pkg::BINS_W-1:0];
               ubh_pkg::CSR_BOTTOM: bottom_ff <= csr_wdata[SAMPLE_WIDTH-1:0];
               default:             width_ff  <= csr_wdata[WW-1:0];
            endcase
            below_ff         <= '0;
            above_ff         <= '0;
            total_ff         <= '0;
            largest_ff       <= '0;
            smallest_seen_ff <= '0;
            largest_seen_ff  <= '0;
            empty_ff         <= 1'b1;
            addr_ff          <= '0;
            pend_ff          <= 1'b0;
            state_ff         <= S_CLEAR;
         end else begin
            case (state_ff)
               S_CLEAR: begin
                  addr_ff <= addr_ff + AW'(1);
                  if (addr_end) begin
                     state_ff <= pend_ff ? S_DONE : S_IDLE;
                  end
               end
               S_IDLE: begin
                  if (accept) begin
                     act_ff    <= ubh_pkg::action_type'(req_action);
                     status_ff <= 1'b0;
                     value_ff  <= '0;
                     minc_ff   <= '0;
                     case (req_action)
                        ubh_pkg::ACT_ADD: begin
                           if (empty_ff || (req_sample < smallest_seen_ff)) begin
                              smallest_seen_ff <= req_sample;
                           end
                           if (empty_ff || (req_sample > largest_seen_ff)) begin
                              largest_seen_ff <= req_sample;
                           end
                           empty_ff <= 1'b0;
                           if (is_below) begin
                              below_ff <= ubh_pkg::sat_inc(below_ff);
                              state_ff <= S_DONE;
                           end else begin
                              state_ff <= S_DIV;
                           end
                        end
                        ubh_pkg::ACT_READ: begin
                           if (NW'(req_bin_index) >= n_act) begin
                              status_ff <= 1'b1;
                              state_ff  <= S_DONE;
                           end else begin
                              addr_ff  <= AW'(req_bin_index);
                              state_ff <= S_RDADDR;
                           end
                        end
                        ubh_pkg::ACT_CLEAR: begin
                           below_ff         <= '0;
                           above_ff         <= '0;
                           total_ff         <= '0;
                           largest_ff       <= '0;
                           smallest_seen_ff <= '0;
                           largest_seen_ff  <= '0;
                           empty_ff         <= 1'b1;
                           addr_ff          <= '0;
                           pend_ff          <= 1'b1;
                           state_ff         <= S_CLEAR;
                        end
                        default: begin
                           addr_ff  <= '0;
                           issue_ff <= 1'b1;
                           vld_ff   <= 1'b0;
                           lastv_ff <= 1'b0;
                           first_ff <= 1'b1;
                           state_ff <= S_SCAN;
                        end
                     endcase
                  end
               end
               S_DIV: begin
                  if (div_done) begin
                     if (div_q >= QN'(n_act)) begin
                        above_ff <= ubh_pkg::sat_inc(above_ff);
                        state_ff <= S_DONE;
                     end else begin
                        addr_ff  <= div_q[AW-1:0];
                        state_ff <= S_RDADDR;
                     end
                  end
               end
               S_RDADDR: begin
                  state_ff <= S_RMW;
               end
               S_RMW: begin
                  if (act_ff == ubh_pkg::ACT_ADD) begin
                     total_ff <= ubh_pkg::sat_inc(total_ff);
                     if (bumped > largest_ff) begin
                        largest_ff <= bumped;
                     end
                  end else begin
                     value_ff <= mem_rdata;
                  end
                  state_ff <= S_DONE;
               end
               S_SCAN: begin
                  vld_ff   <= issue_ff;
                  lastv_ff <= issue_ff && addr_last;
                  if (issue_ff) begin
                     if (addr_last) begin
                        issue_ff <= 1'b0;
                     end else begin
                        addr_ff <= addr_ff + AW'(1);
                     end
                  end
                  if (vld_ff) begin
                     first_ff <= 1'b0;
                     if (first_ff || (mem_rdata < minc_ff)) begin
                        minc_ff <= mem_rdata;
                     end
                     if (lastv_ff) begin
                        state_ff <= S_DONE;
                     end
                  end
               end
               S_DONE: begin
                  if (load_rsp) begin
                     rsp_valid_ff      <= 1'b1;
                     rsp_status_ff     <= status_ff;
                     rsp_bin_value_ff  <= value_ff;
                     rsp_total_ff      <= total_ff;
                     rsp_max_bin_ff    <= largest_ff;
                     rsp_min_bin_ff    <= minc_ff;
                     rsp_below_ff      <= below_ff;
                     rsp_above_ff      <= above_ff;
                     rsp_min_sample_ff <= smallest_seen_ff;
                     rsp_max_sample_ff <= largest_seen_ff;
                     rsp_empty_ff      <= empty_ff;
                     state_ff          <= S_IDLE;
                  end
               end
               default: begin
                  state_ff <= S_IDLE;
               end
            endcase
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_bin_value     = rsp_bin_value_ff;
   assign rsp_total_count   = rsp_total_ff;
   assign rsp_peak_count    = rsp_max_bin_ff;
   assign rsp_least_count   = rsp_min_bin_ff;
   assign rsp_below_count   = rsp_below_ff;
   assign rsp_above_count   = rsp_above_ff;
   assign rsp_min_sample    = rsp_min_sample_ff;
   assign rsp_max_sample    = rsp_max_sample_ff;
   assign rsp_empty_res     = rsp_empty_ff;

endmodule

// ===== sv/ubh_checker.sv =====
// Port-level checker of the uniform bin histogram and its bind statement.
`include "assert_macros.svh"

module ubh_checker #(
   parameter int SAMPLE_WIDTH = ubh_pkg::SAMPLE_WIDTH_DEF
) (
   input logic                           clock,
   input logic                           reset,
   input logic                           rsp_valid,
   input logic                           rsp_ready,
   input logic                           rsp_status,
   input logic [ubh_pkg::CNT_W-1:0]      rsp_bin_value,
   input logic [ubh_pkg::CNT_W-1:0]      rsp_total_count,
   input logic [ubh_pkg::CNT_W-1:0]      rsp_peak_count,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_min_sample,
   input logic signed [SAMPLE_WIDTH-1:0] rsp_max_sample,
   input logic                           rsp_empty_res
);

   // A stalled response stays valid and keeps its total and bin value.
   `UBH_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_count) && $stable(rsp_bin_value), "response changed while stalled")

   // A rejected read reports no count.
   `UBH_ASSERT(a_bad_read, clock, reset, rsp_valid && rsp_status |-> rsp_bin_value == '0, "rejected read carries a count")

   // An empty histogram reports zero extremes.
   `UBH_ASSERT(a_empty_zero, clock, reset, rsp_valid && rsp_empty_res |-> rsp_min_sample == '0 && rsp_max_sample == '0, "empty histogram with nonzero extremes")

   // The smallest sample never lies above the largest.
   `UBH_ASSERT(a_order, clock, reset, rsp_valid && !rsp_empty_res |-> rsp_min_sample <= rsp_max_sample, "sample extremes out of order")

   // No single bin can hold more than the total of all bins.
   `UBH_ASSERT(a_max_total, clock, reset, rsp_valid |-> rsp_peak_count <= rsp_total_count, "largest bin exceeds total")

endmodule

bind uniform_bin_histogram ubh_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ubh_checker (.*);

// ===== tb/histogram_checker.sv =====
// Checker for the uniform bin histogram: watches the ports, predicts each response and compares.
module histogram_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic signed [31:0] req_sample,
   input  logic [9:0]         req_bin_index,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic               rsp_status,
   input  logic [31:0]        rsp_bin_value,
   input  logic [31:0]        rsp_total_count,
   input  logic [31:0]        rsp_peak_count,
   input  logic [31:0]        rsp_least_count,
   input  logic [31:0]        rsp_below_count,
   input  logic [31:0]        rsp_above_count,
   input  logic signed [31:0] rsp_min_sample,
   input  logic signed [31:0] rsp_max_sample,
   input  logic               rsp_empty_res,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 errors,
   output int                 pending
);

   typedef struct {
      logic        status;
      logic [31:0] bin_value;
      logic [31:0] total;
      logic [31:0] max_bin;
      logic [31:0] min_bin;
      logic [31:0] below;
      logic [31:0] above;
      logic [31:0] min_smp;
      logic [31:0] max_smp;
      logic        empty;
   } hist_snapshot_type;

   hist_snapshot_type snapshots_due[$];

   logic [31:0]        bin_tally[1024];
   logic [31:0]        below_cnt, above_cnt, total_cnt, peak_bin;
   logic signed [31:0] lowest_smp, highest_smp;
   logic               none_seen;
   logic [10:0]        bins_reg;
   logic signed [31:0] bottom_reg;
   logic [30:0]        width_reg;

   function automatic logic [31:0] bump(input logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   function automatic longint live_bins();
      if (bins_reg == 0) return 1;
      if (bins_reg > 1024) return 1024;
      return bins_reg;
   endfunction

   task automatic wipe_histogram();
      foreach (bin_tally[i]) bin_tally[i] = '0;
      below_cnt = '0;
      above_cnt = '0;
      total_cnt = '0;
      peak_bin = '0;
      lowest_smp = '0;
      highest_smp = '0;
      none_seen = 1'b1;
   endtask

   task automatic add_to_histogram(input logic signed [31:0] smp);
      longint bot, w, top, s, k;
      bot = bottom_reg;
      w = (width_reg == 0) ? 1 : width_reg;
      s = smp;
      if (none_seen) begin
         lowest_smp = smp;
         highest_smp = smp;
         none_seen = 1'b0;
      end else begin
         if (smp < lowest_smp) lowest_smp = smp;
         if (smp > highest_smp) highest_smp = smp;
      end
      top = bot + live_bins() * w;
      if (s < bot) below_cnt = bump(below_cnt);
      else if (s >= top) above_cnt = bump(above_cnt);
      else begin
         k = (s - bot) / w;
         bin_tally[k] = bump(bin_tally[k]);
         total_cnt = bump(total_cnt);
         if (bin_tally[k] > peak_bin) peak_bin = bin_tally[k];
      end
   endtask

   task automatic predict_request(input logic [1:0] act, input logic signed [31:0] smp,
                                  input logic [9:0] idx);
      hist_snapshot_type snap;
      snap.status = 1'b0;
      snap.bin_value = '0;
      snap.min_bin = '0;
      case (ubh_pkg::action_type'(act))
         ubh_pkg::ACT_ADD: add_to_histogram(smp);
         ubh_pkg::ACT_READ: begin
            if (idx >= live_bins()) snap.status = 1'b1;
            else snap.bin_value = bin_tally[idx];
         end
         ubh_pkg::ACT_CLEAR: wipe_histogram();
         default: begin
            snap.min_bin = bin_tally[0];
            for (int j = 1; j < live_bins(); j++)
               if (bin_tally[j] < snap.min_bin) snap.min_bin = bin_tally[j];
         end
      endcase
      snap.total = total_cnt;
      snap.max_bin = peak_bin;
      snap.below = below_cnt;
      snap.above = above_cnt;
      snap.min_smp = lowest_smp;
      snap.max_smp = highest_smp;
      snap.empty = none_seen;
      snapshots_due.push_back(snap);
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h expected %h", field, got, want);
      errors++;
   endtask

   task automatic check_response();
      hist_snapshot_type want;
      if (snapshots_due.size() == 0) begin
         report_mismatch("response with no request outstanding", 32'd1, 32'd0);
         return;
      end
      want = snapshots_due.pop_front();
      if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
      if (rsp_bin_value !== want.bin_value)
         report_mismatch("bin_value", rsp_bin_value, want.bin_value);
      if (rsp_total_count !== want.total)
         report_mismatch("total_count", rsp_total_count, want.total);
      if (rsp_peak_count !== want.max_bin)
         report_mismatch("peak_count", rsp_peak_count, want.max_bin);
      if (rsp_least_count !== want.min_bin)
         report_mismatch("least_count", rsp_least_count, want.min_bin);
      if (rsp_below_count !== want.below)
         report_mismatch("below_count", rsp_below_count, want.below);
      if (rsp_above_count !== want.above)
         report_mismatch("above_count", rsp_above_count, want.above);
      if (rsp_min_sample !== want.min_smp)
         report_mismatch("min_sample", rsp_min_sample, want.min_smp);
      if (rsp_max_sample !== want.max_smp)
         report_mismatch("max_sample", rsp_max_sample, want.max_smp);
      if (rsp_empty_res !== want.empty)
         report_mismatch("empty_res", rsp_empty_res, want.empty);
   endtask

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         bins_reg = 11'd1;
         bottom_reg = '0;
         width_reg = 31'd1;
         wipe_histogram();
         snapshots_due.delete();
      end else begin
         // The response leaving now belongs to an older request, so check it first.
         if (rsp_valid && rsp_ready) check_response();
         if (csr_we) begin
            case (ubh_pkg::csr_index_type'(csr_index))
               ubh_pkg::CSR_BINS:   bins_reg = csr_wdata[10:0];
               ubh_pkg::CSR_BOTTOM: bottom_reg = csr_wdata;
               ubh_pkg::CSR_WIDTH:  width_reg = csr_wdata[30:0];
               default:             ;
            endcase
            if (ubh_pkg::csr_index_type'(csr_index) != ubh_pkg::CSR_NONE) wipe_histogram();
         end
         if (req_valid && req_ready) predict_request(req_action, req_sample, req_bin_index);
      end
      pending = snapshots_due.size();
   end

endmodule

// ===== tb/tb_top.sv =====
// Top of the uniform bin histogram testbench: clock, reset, stimulus and verdict.
module tb_top;

   // Generous bound on the whole run; clearing passes over the whole bin memory dominate the slow cases.
   localparam longint CYCLE_LIMIT = 4_000_000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_action = ubh_pkg::ACT_READ;
   logic signed [31:0] req_sample = '0;
   logic [9:0]         req_bin_index = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_status;
   logic [31:0]        rsp_bin_value, rsp_total_count, rsp_peak_count, rsp_least_count;
   logic [31:0]        rsp_below_count, rsp_above_count;
   logic signed [31:0] rsp_min_sample, rsp_max_sample;
   logic               rsp_empty_res;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = ubh_pkg::CSR_NONE;
   logic [31:0]        csr_wdata = '0;

   int     errors, pending;
   longint cycles = 0;

   // Idle percentages of the two sides; the phases of the run change them.
   int sender_idle_pct = 15;
   int receiver_idle_pct = 74;

   // Shadow copy of the layout, used only to aim samples and read indices at interesting places.
   longint lay_bins = 1, lay_bottom = 0, lay_width = 1;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("uniform_bin_histogram test failed");
         $finish;
      end
   end

   // The receiver decides its ready on every falling edge.
   always @(negedge clock)
      rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);

   uniform_bin_histogram DUT (.*);

   histogram_checker chk (.*);

   // Writes one layout register. The block clears its histogram on every write.
   task automatic write_reg(input ubh_pkg::csr_index_type idx, input logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      csr_index <= ubh_pkg::CSR_NONE;
      case (idx)
         ubh_pkg::CSR_BINS:   lay_bins = (value[10:0] == 0) ? 1 :
                                         (value[10:0] > 1024) ? 1024 : value[10:0];
         ubh_pkg::CSR_BOTTOM: lay_bottom = longint'($signed(value));
         ubh_pkg::CSR_WIDTH:  lay_width = (value[30:0] == 0) ? 1 : value[30:0];
         default:             ;
      endcase
   endtask

   // Presents one request and holds it until the block takes it.
   task automatic send_request(input ubh_pkg::action_type act, input logic [31:0] smp,
                               input logic [9:0] idx);
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) @(negedge clock);
      req_valid <= 1'b1;
      req_action <= act;
      req_sample <= smp;
      req_bin_index <= idx;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Holds off new requests until every response has come back.
   task automatic drain();
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_sample();
      longint span, off;
      int     sel;
      span = lay_bins * lay_width;
      off = {$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF;
      sel = $urandom_range(0, 9);
      if (sel inside {[0:5]}) return 32'(lay_bottom + off % span);
      case (sel)
         6:       return 32'(lay_bottom - 1 - longint'($urandom_range(0, 32'(3 * lay_width))));
         7:       return 32'(lay_bottom + span + longint'($urandom_range(0, 32'(3 * lay_width))));
         8:       return $urandom;
         default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      endcase
   endfunction

   task automatic random_request();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) send_request(ubh_pkg::ACT_ADD, pick_sample(), 10'($urandom));
      else if (roll < 87) send_request(ubh_pkg::ACT_READ, $urandom,
                                       10'(($urandom_range(0, 3) == 0) ? $urandom :
                                           $urandom_range(0, 32'(lay_bins - 1))));
      else if (roll < 97) send_request(ubh_pkg::ACT_SCAN, $urandom, 10'($urandom));
      else send_request(ubh_pkg::ACT_CLEAR, $urandom, 10'($urandom));
   endtask

   // Layouts for the random phases, extremes included. A bin count of zero acts
   // as one and a count above the store depth acts as the full depth.
   logic [31:0] layout_bins[8]   = '{32'd16, 32'd1, 32'd1024, 32'd0, 32'd2047, 32'd7, 32'd64,
                                     32'd3};
   logic [31:0] layout_bottom[8] = '{32'hFFFF_FF00, 32'h8000_0000, 32'h7FFF_FF00, 32'd0,
                                     32'hC000_0000, 32'h7FFF_FFFF, 32'h0001_0000,
                                     32'h8000_0000};
   logic [31:0] layout_width[8]  = '{32'd16, 32'h7FFF_FFFF, 32'd1, 32'd0, 32'h0001_0000,
                                     32'd5, 32'h0000_8000, 32'h7FFF_FFFF};

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: eight bins of width ten starting at -100.
      write_reg(ubh_pkg::CSR_BINS, 32'd8);
      write_reg(ubh_pkg::CSR_BOTTOM, 32'hFFFF_FF9C);
      write_reg(ubh_pkg::CSR_WIDTH, 32'd10);
      send_request(ubh_pkg::ACT_SCAN, '0, '0);            // scan of an empty store
      send_request(ubh_pkg::ACT_ADD, 32'hFFFF_FF9B, '0);  // just below the bottom edge
      send_request(ubh_pkg::ACT_ADD, 32'hFFFF_FF9C, '0);  // exactly on the bottom edge
      send_request(ubh_pkg::ACT_ADD, 32'hFFFF_FFDB, '0);  // a value inside bin 6
      send_request(ubh_pkg::ACT_ADD, 32'hFFFF_FFEC, '0);  // exactly on the top edge
      send_request(ubh_pkg::ACT_ADD, 32'h8000_0000, '0);  // most negative sample
      send_request(ubh_pkg::ACT_ADD, 32'h7FFF_FFFF, '0);  // most positive sample
      send_request(ubh_pkg::ACT_ADD, 32'hFFFF_FFA5, 10'h3FF);
      send_request(ubh_pkg::ACT_ADD, 32'hFFFF_FFA6, 10'h3FF);
      send_request(ubh_pkg::ACT_READ, 32'hFFFF_FFFF, 10'd0);
      send_request(ubh_pkg::ACT_READ, '0, 10'd7);
      send_request(ubh_pkg::ACT_READ, '0, 10'd8);         // first index past the active bins
      send_request(ubh_pkg::ACT_READ, '0, 10'h3FF);       // largest index
      send_request(ubh_pkg::ACT_SCAN, '0, '0);
      send_request(ubh_pkg::ACT_CLEAR, '0, '0);
      send_request(ubh_pkg::ACT_READ, '0, 10'd0);
      send_request(ubh_pkg::ACT_SCAN, '0, '0);
      send_request(ubh_pkg::ACT_ADD, 32'hFFFF_FFB0, '0);
      drain();

      // Random part: eight layouts of a hundred requests. Idling moves from a
      // slow receiver to a slow sender and then to no idling at all.
      for (int ph = 0; ph < 8; ph++) begin
         if (ph == 3) begin
            sender_idle_pct = 74;
            receiver_idle_pct = 15;
         end else if (ph == 6) begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
         end
         write_reg(ubh_pkg::CSR_BINS, layout_bins[ph]);
         write_reg(ubh_pkg::CSR_BOTTOM, layout_bottom[ph]);
         write_reg(ubh_pkg::CSR_WIDTH, layout_width[ph]);
         for (int n = 0; n < 100; n++) random_request();
         drain();
      end

      repeat (40) @(posedge clock);
      if (errors == 0 && pending == 0) begin
         $display("uniform_bin_histogram test passed");
      end else begin
         $display("uniform_bin_histogram test failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ubh_pkg.sv
sv/ubh_divider.sv
sv/ubh_bin_ram.sv
sv/uniform_bin_histogram.sv
sv/ubh_checker.sv
tb/histogram_checker.sv
tb/tb_top.sv
